[rtl/idi_pkg.sv]
// Package for the iso-crossing depth interpolator: default sizes, the
// reset base of the null depth, register indexes and the sequencer states.
// No dependencies.
`default_nettype none

package idi_pkg;

    localparam int IDI_VALUE_WIDTH   = 32;
    localparam int IDI_FRACTION_BITS = 12;
    localparam int IDI_NULL_BASE     = 99999;

    typedef enum logic [0:0] {
        REG_ISO_VALUE  = 1'b0,
        REG_NULL_VALUE = 1'b1
    } t_reg_idx;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_EVAL  = 9'b000000010,
        S_ABS_A = 9'b000000100,
        S_ABS_D = 9'b000001000,
        S_ABS_B = 9'b000010000,
        S_MUL   = 9'b000100000,
        S_DIV   = 9'b001000000,
        S_FIN   = 9'b010000000,
        S_EMIT  = 9'b100000000
    } t_state;

endpackage

`default_nettype wire

[rtl/iso_crossing_depth_interpolator.sv]
// Iso-surface crossing depth of one grid column by linear interpolation.
// Sequence: each sample is taken in idle and evaluated; a crossing sample then
// runs the absolute values, the shift-add multiply and restoring divide, both on
// one shared adder, one bit a cycle, and a final signed add. No new sample is taken
// until the last is through; a column end passes an emit state before the result shows.
// Reset: synchronous, active low; resets the sequencer, column state, config registers and output valid.
`default_nettype none

module iso_crossing_depth_interpolator
    import idi_pkg::*;
#(
    parameter int VALUE_WIDTH   = IDI_VALUE_WIDTH,
    parameter int FRACTION_BITS = IDI_FRACTION_BITS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // cfg write port
    input  wire logic                     i_cfg_we,
    input  wire logic                     i_cfg_addr,
    input  wire logic [VALUE_WIDTH-1:0]   i_cfg_wdata,
    // slave side
    input  wire logic                     s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata: prop_sample, depth_sample (low bits up), zero padded
    input  wire logic [((2*VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // tuser: segment_start
    input  wire logic                     s_axis_tuser,
    input  wire logic                     s_axis_tlast,
    // master side
    output logic                          m_axis_tvalid,
    input  wire logic                     m_axis_tready,
    // tdata: iso_depth, zero padded
    output logic [((VALUE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // tuser: found
    output logic                          m_axis_tuser
);

    localparam int W      = VALUE_WIDTH;
    localparam int OUT_W  = ((VALUE_WIDTH+7)/8)*8;
    localparam int CNT_W  = $clog2(VALUE_WIDTH);
    localparam logic [W-1:0] NULL_RESET = W'(64'(IDI_NULL_BASE) << FRACTION_BITS);

    t_state         r_state, n_state;
    logic [W-1:0]   r_iso, n_iso;
    logic [W-1:0]   r_null, n_null;
    logic [W-1:0]   r_up, n_up;
    logic [W-1:0]   r_ud, n_ud;
    logic           r_have, n_have;
    logic           r_found, n_found;
    logic [W-1:0]   r_depth, n_depth;
    logic           r_out_valid, n_out_valid;
    logic [W-1:0]   r_out_depth, n_out_depth;
    logic           r_out_found, n_out_found;
    logic [W-1:0]   r_lp, n_lp;
    logic [W-1:0]   r_ld, n_ld;
    logic           r_seg, n_seg;
    logic           r_last, n_last;
    logic [W-1:0]   r_a, n_a;
    logic [W-1:0]   r_d, n_d;
    logic [W-1:0]   r_hi, n_hi;
    logic [W-1:0]   r_lo, n_lo;
    logic           r_neg, n_neg;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic [W-1:0]   cmp_x, cmp_y;
    logic           cmp_lt;
    logic [W+1:0]   u_x, u_y, u_sum;
    logic           u_sub;
    logic [W:0]     acc;
    logic           in_range;
    logic           lp_lt_up;
    logic [W-1:0]   mn, mx;
    t_state         done_state;

    function automatic logic [W+1:0] sx(input logic [W-1:0] v);
        sx = {{2{v[W-1]}}, v};
    endfunction

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'(r_out_depth);
    assign m_axis_tuser  = r_out_found;

    assign lp_lt_up = $signed(r_lp) < $signed(r_up);
    assign mn       = lp_lt_up ? r_lp : r_up;
    assign mx       = lp_lt_up ? r_up : r_lp;
    assign in_range = !($signed(r_iso) < $signed(mn)) && !($signed(mx) < $signed(r_iso));
    assign cmp_lt   = $signed(cmp_x) < $signed(cmp_y);
    assign done_state = r_last ? S_EMIT : S_IDLE;

    // shared adder operand select
    always_comb begin
        cmp_x = r_iso;
        cmp_y = r_up;
        u_x   = '0;
        u_y   = '0;
        u_sub = 1'b0;
        case (r_state)
            S_ABS_A, S_ABS_D, S_ABS_B: begin
                if (r_state == S_ABS_A) begin
                    cmp_x = r_iso;
                    cmp_y = r_up;
                end else if (r_state == S_ABS_D) begin
                    cmp_x = r_lp;
                    cmp_y = r_up;
                end else begin
                    cmp_x = r_ld;
                    cmp_y = r_ud;
                end
                u_x   = cmp_lt ? sx(cmp_y) : sx(cmp_x);
                u_y   = cmp_lt ? sx(cmp_x) : sx(cmp_y);
                u_sub = 1'b1;
            end
            S_MUL: begin
                u_x = {2'b00, r_hi};
                u_y = {2'b00, r_a};
            end
            S_DIV: begin
                u_x   = {1'b0, r_hi, r_lo[W-1]};
                u_y   = {2'b00, r_d};
                u_sub = 1'b1;
            end
            S_FIN: begin
                u_x   = sx(r_ud);
                u_y   = {2'b00, r_lo};
                u_sub = r_neg;
            end
            default: begin
                u_sub = 1'b0;
            end
        endcase
    end

    assign u_sum = u_x + (u_y ^ {(W+2){u_sub}}) + (W+2)'(u_sub);
    assign acc   = r_lo[0] ? u_sum[W:0] : {1'b0, r_hi};

    always_comb begin
        n_state     = r_state;
        n_iso       = r_iso;
        n_null      = r_null;
        n_up        = r_up;
        n_ud        = r_ud;
        n_have      = r_have;
        n_found     = r_found;
        n_depth     = r_depth;
        n_out_valid = r_out_valid;
        n_out_depth = r_out_depth;
        n_out_found = r_out_found;
        n_lp        = r_lp;
        n_ld        = r_ld;
        n_seg       = r_seg;
        n_last      = r_last;
        n_a         = r_a;
        n_d         = r_d;
        n_hi        = r_hi;
        n_lo        = r_lo;
        n_neg       = r_neg;
        n_cnt       = r_cnt;

        if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_ISO_VALUE:  n_iso  = i_cfg_wdata;
                REG_NULL_VALUE: n_null = i_cfg_wdata;
                default:        n_iso  = r_iso;
            endcase
        end

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_lp    = s_axis_tdata[W-1:0];
                    n_ld    = s_axis_tdata[2*W-1:W];
                    n_seg   = s_axis_tuser;
                    n_last  = s_axis_tlast;
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (r_seg || !r_have) begin
                    n_up    = r_lp;
                    n_ud    = r_ld;
                    n_have  = 1'b1;
                    n_state = done_state;
                end else if (in_range) begin
                    n_state = r_found ? done_state : S_ABS_A;
                end else begin
                    n_up    = r_lp;
                    n_ud    = r_ld;
                    n_state = done_state;
                end
            end
            S_ABS_A: begin
                n_a     = u_sum[W-1:0];
                n_neg   = cmp_lt;
                n_state = S_ABS_D;
            end
            S_ABS_D: begin
                n_d     = u_sum[W-1:0];
                n_neg   = r_neg ^ cmp_lt;
                n_state = S_ABS_B;
            end
            S_ABS_B: begin
                n_neg = r_neg ^ cmp_lt;
                n_hi  = '0;
                n_lo  = u_sum[W-1:0];
                n_cnt = '0;
                if (r_a == '0 || u_sum[W-1:0] == '0) begin
                    n_lo    = '0;
                    n_state = S_FIN;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_hi  = acc[W:1];
                n_lo  = {acc[0], r_lo[W-1:1]};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(W-1)) begin
                    n_cnt   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_hi  = u_sum[W+1] ? u_x[W-1:0] : u_sum[W-1:0];
                n_lo  = {r_lo[W-2:0], !u_sum[W+1]};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(W-1)) begin
                    n_cnt   = '0;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_depth = u_sum[W-1:0];
                n_found = 1'b1;
                n_state = done_state;
            end
            S_EMIT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_depth = r_found ? r_depth : r_null;
                    n_out_found = r_found;
                    n_have      = 1'b0;
                    n_found     = 1'b0;
                    n_depth     = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_iso       <= '0;
            r_null      <= NULL_RESET;
            r_up        <= '0;
            r_ud        <= '0;
            r_have      <= 1'b0;
            r_found     <= 1'b0;
            r_depth     <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_iso       <= n_iso;
            r_null      <= n_null;
            r_up        <= n_up;
            r_ud        <= n_ud;
            r_have      <= n_have;
            r_found     <= n_found;
            r_depth     <= n_depth;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_depth <= n_out_depth;
        r_out_found <= n_out_found;
        r_lp        <= n_lp;
        r_ld        <= n_ld;
        r_seg       <= n_seg;
        r_last      <= n_last;
        r_a         <= n_a;
        r_d         <= n_d;
        r_hi        <= n_hi;
        r_lo        <= n_lo;
        r_neg       <= n_neg;
    end

endmodule

`default_nettype wire

[rtl/idi_checker.sv]
// Port-level checks for the iso-crossing depth interpolator, bound to the
// top level. Depends on idi_pkg for default sizes and register indexes.
`default_nettype none

module idi_checker
    import idi_pkg::*;
#(
    parameter int VALUE_WIDTH   = IDI_VALUE_WIDTH,
    parameter int FRACTION_BITS = IDI_FRACTION_BITS
) (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     i_cfg_we,
    input wire logic                     i_cfg_addr,
    input wire logic [VALUE_WIDTH-1:0]   i_cfg_wdata,
    input wire logic                     s_axis_tvalid,
    input wire logic                     s_axis_tready,
    input wire logic [((2*VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    input wire logic                     s_axis_tuser,
    input wire logic                     s_axis_tlast,
    input wire logic                     m_axis_tvalid,
    input wire logic                     m_axis_tready,
    input wire logic [((VALUE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    input wire logic                     m_axis_tuser
);

    localparam logic [VALUE_WIDTH-1:0] NULL_RESET =
        VALUE_WIDTH'(64'(IDI_NULL_BASE) << FRACTION_BITS);

    logic [VALUE_WIDTH-1:0] r_null;

    // track the null depth as written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_null <= NULL_RESET;
        end else if (i_cfg_we && i_cfg_addr == REG_NULL_VALUE) begin
            r_null <= i_cfg_wdata;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while previous one still in work");

    a_null_on_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            m_axis_tdata[VALUE_WIDTH-1:0] == r_null)
        else $error("missed column does not report the null depth");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind iso_crossing_depth_interpolator idi_checker #(
    .VALUE_WIDTH   (VALUE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
) u_idi_checker (.*);

`default_nettype wire

[tb/idi_depth_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for iso_crossing_depth_interpolator: follows the register port and
// both stream sides, predicts each column's crossing depth and compares results.
// Depends on idi_pkg.
module idi_depth_checker
    import idi_pkg::*;
#(
    parameter int VW = IDI_VALUE_WIDTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_addr,
    input  wire logic [VW-1:0] i_cfg_wdata,
    input  wire logic          i_s_tvalid,
    input  wire logic          i_s_tready,
    // prop_sample, depth_sample
    input  wire logic [((2*VW+7)/8)*8-1:0] i_s_tdata,
    // segment_start
    input  wire logic          i_s_tuser,
    input  wire logic          i_s_tlast,
    input  wire logic          i_m_tvalid,
    input  wire logic          i_m_tready,
    // iso_depth
    input  wire logic [((VW+7)/8)*8-1:0] i_m_tdata,
    // found
    input  wire logic          i_m_tuser,
    output int                 o_mismatches,
    output int                 o_pending,
    output int                 o_columns,
    output int                 o_crossings
);

    typedef logic signed [VW-1:0] t_value;

    typedef struct packed {
        t_value depth;
        logic   found;
    } t_column_result;

    localparam t_value NULL_DEFAULT = IDI_NULL_BASE << IDI_FRACTION_BITS;

    t_column_result column_results_q[$];

    t_value iso_level;
    t_value null_depth;
    t_value upper_prop;
    t_value upper_depth;
    t_value crossing_depth;
    logic   have_upper;
    logic   crossing_found;

    function automatic t_value interpolate_depth(input t_value iso, input t_value up,
                                                 input t_value lp, input t_value ud,
                                                 input t_value ld);
        logic signed [VW:0] num;
        logic signed [VW:0] den;
        logic signed [VW:0] span;
        logic [VW:0]        a;
        logic [VW:0]        d;
        logic [VW:0]        b;
        logic [2*VW+1:0]    prod;
        logic [2*VW+1:0]    quo;
        num = iso - up;
        den = lp - up;
        span = ld - ud;
        a = num[VW] ? -num : num;
        d = den[VW] ? -den : den;
        b = span[VW] ? -span : span;
        if (a == 0 || b == 0 || d == 0)
            return ud;
        prod = a * b;
        quo = prod / d;
        if (num[VW] ^ den[VW] ^ span[VW])
            return ud - quo[VW-1:0];
        return ud + quo[VW-1:0];
    endfunction

    task automatic flag_mismatch(input string msg);
        o_mismatches++;
        $display("%0t ns mismatch: %s", $time, msg);
    endtask

    task automatic absorb_sample(input t_value prop, input t_value depth, input logic seg,
                                 input logic last);
        t_value         lo_v;
        t_value         hi_v;
        t_column_result r;
        if (seg || !have_upper) begin
            upper_prop = prop;
            upper_depth = depth;
            have_upper = 1'b1;
        end else begin
            lo_v = (prop < upper_prop) ? prop : upper_prop;
            hi_v = (prop < upper_prop) ? upper_prop : prop;
            if (iso_level >= lo_v && iso_level <= hi_v) begin
                if (!crossing_found) begin
                    crossing_depth = interpolate_depth(iso_level, upper_prop, prop,
                                                       upper_depth, depth);
                    crossing_found = 1'b1;
                end
            end else begin
                upper_prop = prop;
                upper_depth = depth;
            end
        end
        if (last) begin
            r.depth = crossing_found ? crossing_depth : null_depth;
            r.found = crossing_found;
            column_results_q.push_back(r);
            have_upper = 1'b0;
            crossing_found = 1'b0;
            crossing_depth = '0;
        end
    endtask

    task automatic check_result(input t_value depth, input logic found);
        t_column_result want;
        if (column_results_q.size() == 0) begin
            flag_mismatch($sformatf("unexpected result depth %0d found %0b", depth, found));
            return;
        end
        want = column_results_q.pop_front();
        o_columns++;
        if (want.found)
            o_crossings++;
        if (depth !== want.depth)
            flag_mismatch($sformatf("iso_depth %0d, expected %0d", depth, want.depth));
        if (found !== want.found)
            flag_mismatch($sformatf("found %0b, expected %0b", found, want.found));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            iso_level = '0;
            null_depth = NULL_DEFAULT;
            upper_prop = '0;
            upper_depth = '0;
            crossing_depth = '0;
            have_upper = 1'b0;
            crossing_found = 1'b0;
            column_results_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready)
                check_result(i_m_tdata[VW-1:0], i_m_tuser);
            if (i_s_tvalid && i_s_tready)
                absorb_sample(i_s_tdata[VW-1:0], i_s_tdata[2*VW-1:VW], i_s_tuser, i_s_tlast);
            if (i_cfg_we) begin
                if (t_reg_idx'(i_cfg_addr) == REG_ISO_VALUE)
                    iso_level = i_cfg_wdata;
                else if (t_reg_idx'(i_cfg_addr) == REG_NULL_VALUE)
                    null_depth = i_cfg_wdata;
            end
        end
        o_pending = column_results_q.size();
    end

endmodule

[tb/iso_crossing_depth_interpolator_test.sv]
`timescale 1ns / 1ps
// Top of the iso_crossing_depth_interpolator testbench: register writes, column
// samples with random gaps, result-side stalls and the verdict.
// Depends on idi_pkg, idi_depth_checker and the block itself.
module iso_crossing_depth_interpolator_test;
    import idi_pkg::*;

    localparam int VW                = IDI_VALUE_WIDTH;
    localparam int S_TDATA_W         = ((2*VW+7)/8)*8;
    localparam int M_TDATA_W         = ((VW+7)/8)*8;
    localparam int DRAIN_CYCLES      = 2*VW + 16;
    localparam int ITEMS_PER_SETTING = 210;
    localparam int SETTINGS_COUNT    = 6;

    localparam logic [VW-1:0] NULL_DEFAULT = IDI_NULL_BASE << IDI_FRACTION_BITS;
    localparam logic [VW-1:0] VALUE_MIN    = {1'b1, {(VW-1){1'b0}}};
    localparam logic [VW-1:0] VALUE_MAX    = {1'b0, {(VW-1){1'b1}}};

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic                 i_cfg_addr    = 1'b0;
    logic [VW-1:0]        i_cfg_wdata   = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 s_axis_tuser  = 1'b0;
    logic                 s_axis_tlast  = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tuser;

    int src_idle_pct   = 30;
    int sink_stall_pct = 82;
    int mismatches;
    int pending;
    int columns;
    int crossings;
    int samples_sent   = 0;
    int settings_used  = 1;

    logic signed [VW-1:0] cur_iso = '0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    iso_crossing_depth_interpolator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    idi_depth_checker #(.VW(VW)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_s_tlast    (s_axis_tlast),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_columns    (columns),
        .o_crossings  (crossings)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic push_sample(input logic [VW-1:0] prop, input logic [VW-1:0] depth,
                               input logic seg, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {depth, prop};
        s_axis_tuser  <= seg;
        s_axis_tlast  <= last;
        @(negedge i_clk);
        while (!s_axis_tready)
            @(negedge i_clk);
        @(posedge i_clk);
        samples_sent++;
    endtask

    task automatic load_settings(input logic [VW-1:0] iso, input logic [VW-1:0] nul_depth);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= REG_ISO_VALUE;
        i_cfg_wdata <= iso;
        @(posedge i_clk);
        i_cfg_addr  <= REG_NULL_VALUE;
        i_cfg_wdata <= nul_depth;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_iso = iso;
        settings_used++;
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [VW-1:0] prop_near(input logic signed [VW-1:0] iso,
                                                input int unsigned spread);
        longint v;
        v = longint'(iso) + longint'($urandom_range(2*spread)) - longint'(spread);
        if (v > longint'(signed'(VALUE_MAX)))
            v = longint'(signed'(VALUE_MAX));
        if (v < longint'(signed'(VALUE_MIN)))
            v = longint'(signed'(VALUE_MIN));
        return v[VW-1:0];
    endfunction

    task automatic run_columns(input int n_items);
        int            sent;
        int            len;
        int            k;
        int            style;
        int unsigned   spread;
        logic [VW-1:0] prop;
        logic [VW-1:0] depth;
        sent = 0;
        while (sent < n_items) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 6);
            style = $urandom_range(9);
            case ($urandom_range(3))
                0: spread = 8;
                1: spread = 1 << 12;
                2: spread = 1 << 24;
                default: spread = 0;
            endcase
            depth = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 1 << 24);
            for (k = 0; k < len; k++) begin
                if (style == 0) begin
                    push_sample($urandom, $urandom, 1'($urandom_range(1)),
                                (k == len - 1) || ($urandom_range(3) == 0));
                end else begin
                    prop = (spread == 0) ? $urandom : prop_near(cur_iso, spread);
                    depth = depth + (($urandom_range(4) == 0) ? $urandom
                                                              : $urandom_range(0, 1 << 16));
                    push_sample(prop, depth,
                                (k == 0) ? 1'($urandom_range(1)) : ($urandom_range(5) == 0),
                                k == len - 1);
                end
            end
            sent += len;
        end
    endtask

    initial begin
        int            phase;
        logic [VW-1:0] iso;
        logic [VW-1:0] nul_depth;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // lone first node, then a plain crossing on the column's last node
        push_sample(7, 11, 1'b0, 1'b1);
        push_sample(-100, 0, 1'b1, 1'b0);
        push_sample(100, 1000, 1'b0, 1'b1);
        // equal pair values, at and off the iso value
        push_sample(0, 50, 1'b0, 1'b0);
        push_sample(0, 90, 1'b0, 1'b1);
        push_sample(5, 0, 1'b0, 1'b0);
        push_sample(5, 10, 1'b0, 1'b1);
        // drop a later crossing in a later segment
        push_sample(-10, 0, 1'b0, 1'b0);
        push_sample(10, 100, 1'b0, 1'b0);
        push_sample(-5, 200, 1'b1, 1'b0);
        push_sample(5, 300, 1'b0, 1'b1);
        // advance the upper node, then cross downward
        push_sample(10, 0, 1'b0, 1'b0);
        push_sample(20, 100, 1'b0, 1'b0);
        push_sample(-20, 200, 1'b0, 1'b1);
        // segment start breaks a pair that would cross
        push_sample(-10, 0, 1'b0, 1'b0);
        push_sample(10, 100, 1'b1, 1'b0);
        push_sample(20, 200, 1'b0, 1'b1);
        // full-range values and depths
        push_sample(VALUE_MIN, VALUE_MIN, 1'b0, 1'b0);
        push_sample(VALUE_MAX, VALUE_MAX, 1'b0, 1'b1);
        push_sample(VALUE_MAX, VALUE_MIN, 1'b1, 1'b0);
        push_sample(VALUE_MIN, VALUE_MAX, 1'b0, 1'b1);
        // crossing depth equal to the null depth
        push_sample(0, NULL_DEFAULT, 1'b0, 1'b0);
        push_sample(0, 3, 1'b0, 1'b1);
        push_sample(1, 2, 1'b1, 1'b1);
        settle();

        for (phase = 0; phase < SETTINGS_COUNT; phase++) begin
            case (phase)
                0: begin
                    iso = $urandom_range(0, 1 << 21) - (1 << 20);
                    nul_depth = VALUE_MAX;
                end
                1: begin
                    iso = VALUE_MIN;
                    nul_depth = VALUE_MIN;
                end
                2: begin
                    iso = VALUE_MAX;
                    nul_depth = $urandom;
                    src_idle_pct = 82;
                    sink_stall_pct = 30;
                end
                3: begin
                    iso = $urandom;
                    nul_depth = '0;
                end
                4: begin
                    iso = '0;
                    nul_depth = NULL_DEFAULT;
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                end
                default: begin
                    iso = $urandom;
                    nul_depth = $urandom;
                end
            endcase
            load_settings(iso, nul_depth);
            run_columns(ITEMS_PER_SETTING);
            settle();
        end

        $display("Sent %0d samples in %0d columns, %0d of them with a crossing,",
                 samples_sent, columns, crossings);
        $display("under %0d register settings and three idle patterns.", settings_used);
        if (mismatches == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

[sim.f]
rtl/idi_pkg.sv
rtl/iso_crossing_depth_interpolator.sv
rtl/idi_checker.sv
tb/idi_depth_checker.sv
tb/iso_crossing_depth_interpolator_test.sv
